// File: design/mse_pkg.sv
// Shared types and constants for the merge sort engine.
package mse_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned DataW    = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    end_of_run;
    logic                    overflow;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

endpackage

// File: design/mse_cell.sv
// One sorting cell: holds one element, inserts in order or shifts toward the head.
module mse_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mse_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [mse_pkg::DataW-1:0]    x_i,
  input  logic                                left_lt_i,
  input  logic signed [mse_pkg::DataW-1:0]    left_val_i,
  input  logic                                left_vld_i,
  input  logic signed [mse_pkg::DataW-1:0]    right_val_i,
  input  logic                                right_vld_i,
  output logic                                lt_o,
  output logic signed [mse_pkg::DataW-1:0]    val_o,
  output logic                                vld_o
);

  logic signed [mse_pkg::DataW-1:0] val_q, val_d;
  logic                             vld_q, vld_d;

  // new element belongs at or before this slot
  assign lt_o  = !vld_q || (x_i < val_q);
  assign val_o = val_q;
  assign vld_o = vld_q;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.shift) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end else if (ctrl_i.insert) begin
      if (left_lt_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else if (lt_o) begin
        val_d = x_i;
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: design/mse_ctrl.sv
// Load/drain sequencer: element count, drop flag and cell control.
module mse_ctrl #(
  parameter int unsigned MAX_ITEMS = mse_pkg::MaxItems
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                end_of_run_o,
  output logic                overflow_o,
  output mse_pkg::cell_ctrl_t cell_ctrl_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  mse_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic            in_acc, out_acc, has_room;

  assign has_room = cnt_q < CntW'(MAX_ITEMS);
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    case (state_q)
      mse_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_last_i) begin
            state_d = mse_pkg::ST_DRAIN;
          end
        end
      end
      mse_pkg::ST_DRAIN: begin
        if (out_acc) begin
          cnt_d = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            drop_d  = 1'b0;
            state_d = mse_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = mse_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    cell_ctrl_o.insert = 1'b0;
    cell_ctrl_o.shift  = 1'b0;
    case (state_q)
      mse_pkg::ST_LOAD: begin
        in_ready_o         = 1'b1;
        cell_ctrl_o.insert = in_valid_i && has_room;
      end
      mse_pkg::ST_DRAIN: begin
        out_valid_o       = 1'b1;
        cell_ctrl_o.shift = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign end_of_run_o = cnt_q == CntW'(1);
  assign overflow_o   = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mse_pkg::ST_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
    end
  end

endmodule

// File: design/merge_sort_engine_top.sv
// Top level of the merge sort engine: sequencer plus a row of sorting cells.
//
//  channel | signals                                  | transaction
//  --------+------------------------------------------+------------------------------
//  in      | in_valid_i, in_ready_o, in_data_i        | one element, is_last ends set
//  out     | out_valid_o, out_ready_i, out_data_o     | one sorted element
//
// While loading, input is always ready; each element that fits is placed in order
// across the cell row in the cycle it is accepted, and further elements are dropped
// and set the overflow flag. After is_last, the row drains one element per cycle from
// its head. Input is not taken while draining. Output stalls simply hold the row.
// Reset empties all cells and clears the count and overflow flag.
module merge_sort_engine_top #(
  parameter int unsigned MAX_ITEMS = mse_pkg::MaxItems
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mse_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mse_pkg::out_item_t out_data_o
);

  mse_pkg::cell_ctrl_t              cell_ctrl;
  logic signed [mse_pkg::DataW-1:0] cell_val [MAX_ITEMS];
  logic                             cell_vld [MAX_ITEMS];
  logic                             cell_lt  [MAX_ITEMS];
  logic                             end_of_run, overflow;

  mse_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_last_i    (in_data_i.is_last),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .end_of_run_o (end_of_run),
    .overflow_o   (overflow),
    .cell_ctrl_o  (cell_ctrl)
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                             left_lt, left_vld, right_vld;
    logic signed [mse_pkg::DataW-1:0] left_val, right_val;

    if (i == 0) begin : g_head
      assign left_lt  = 1'b0;
      assign left_val = '0;
      assign left_vld = 1'b0;
    end else begin : g_body
      assign left_lt  = cell_lt[i-1];
      assign left_val = cell_val[i-1];
      assign left_vld = cell_vld[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
      assign right_vld = cell_vld[i+1];
    end

    mse_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .x_i         (in_data_i.value),
      .left_lt_i   (left_lt),
      .left_val_i  (left_val),
      .left_vld_i  (left_vld),
      .right_val_i (right_val),
      .right_vld_i (right_vld),
      .lt_o        (cell_lt[i]),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i])
    );
  end

  assign out_data_o.sorted_value = cell_val[0];
  assign out_data_o.end_of_run   = end_of_run;
  assign out_data_o.overflow     = overflow;

endmodule

// File: tb/tb.sv
// Testbench for merge_sort_engine_top: random sequences, ordered-insert predictor, scoreboard.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 2 * mse_pkg::MaxItems + 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  mse_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  mse_pkg::out_item_t out_data_o;

  mse_pkg::in_item_t  pending_in[$];
  mse_pkg::out_item_t expected_out[$];
  int                 sorted_run[$];
  bit                 run_overflowed = 1'b0;

  int unsigned tx_idle_pct = 34;
  int unsigned rx_idle_pct = 69;
  bit          hold_armed = 1'b0;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  merge_sort_engine_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Keeps the held elements in ascending order; a set is_last releases the whole run.
  task automatic file_element(input mse_pkg::in_item_t it);
    int pos;
    mse_pkg::out_item_t res;
    pos = 0;
    if (sorted_run.size() < mse_pkg::MaxItems) begin
      while (pos < sorted_run.size() && sorted_run[pos] <= int'(it.value)) pos++;
      sorted_run.insert(pos, int'(it.value));
    end else begin
      run_overflowed = 1'b1;
    end
    if (it.is_last) begin
      for (int k = 0; k < sorted_run.size(); k++) begin
        res.sorted_value = sorted_run[k];
        res.end_of_run   = (k == sorted_run.size() - 1);
        res.overflow     = run_overflowed;
        expected_out.push_back(res);
      end
      sorted_run.delete();
      run_overflowed = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) file_element(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_in.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_in.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once armed.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_armed && !hold_done && out_valid_o) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_out
    mse_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        if (fail_count < 10)
          $display("ERROR: unexpected transaction value=%0d end=%0b ovf=%0b",
                   out_data_o.sorted_value, out_data_o.end_of_run, out_data_o.overflow);
        fail_count++;
      end else begin
        want = expected_out.pop_front();
        if (out_data_o !== want) begin
          if (fail_count < 10)
            $display("ERROR: exp value=%0d end=%0b ovf=%0b, got value=%0d end=%0b ovf=%0b",
                     want.sorted_value, want.end_of_run, want.overflow,
                     out_data_o.sorted_value, out_data_o.end_of_run, out_data_o.overflow);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [mse_pkg::DataW-1:0] pick_value();
    logic signed [mse_pkg::DataW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = {1'b1, {(mse_pkg::DataW-1){1'b0}}};
      1:       v = {1'b0, {(mse_pkg::DataW-1){1'b1}}};
      2, 3:    v = $urandom_range(0, 8) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_item(input logic signed [mse_pkg::DataW-1:0] v, input logic last);
    mse_pkg::in_item_t it;
    it.value   = v;
    it.is_last = last;
    pending_in.push_back(it);
  endtask

  task automatic add_sequence(input int len);
    for (int i = 0; i < len; i++) add_item(pick_value(), i == len - 1);
  endtask

  task automatic add_random_phase(input int first_len, input int target);
    int total;
    int len;
    add_sequence(first_len);
    total = first_len;
    while (total < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      if (total + len > target) len = target - total;
      add_sequence(len);
      total += len;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_in.size() != 0 || in_valid_i || expected_out.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single element, extremes, descending run, ties, alternating bits
    add_item(32'sh7fff_ffff, 1'b1);
    add_item(32'sh8000_0000, 1'b0);
    add_item(32'sh7fff_ffff, 1'b0);
    add_item(0, 1'b0);
    add_item(-1, 1'b0);
    add_item(1, 1'b0);
    add_item(32'sh8000_0000, 1'b0);
    add_item(5, 1'b0);
    add_item(5, 1'b0);
    add_item(-5, 1'b1);
    add_item(3, 1'b0);
    add_item(2, 1'b0);
    add_item(1, 1'b0);
    add_item(0, 1'b1);
    add_item(7, 1'b0);
    add_item(7, 1'b0);
    add_item(7, 1'b1);
    add_item(32'sh5555_5555, 1'b0);
    add_item(32'shaaaa_aaaa, 1'b1);

    // exactly full, then drops mid-run and on the last element
    add_random_phase(mse_pkg::MaxItems, 80);
    wait_idle();

    @(negedge clk_i);
    tx_idle_pct = 69;
    rx_idle_pct = 34;
    add_random_phase(mse_pkg::MaxItems + 2, 80);
    wait_idle();

    @(negedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_armed  = 1'b1;
    add_random_phase(mse_pkg::MaxItems + 1, 80);
    wait_idle();

    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_out.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mse_pkg.sv
design/mse_cell.sv
design/mse_ctrl.sv
design/merge_sort_engine_top.sv
tb/tb.sv
